/* rtl/gpsr_pkg.sv */
// package for the gpio port: constants, operation codes and queue entry type
package gpsr_pkg;

	localparam int PIN_COUNT = 16;
	localparam int LATCH_W   = 16;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 10;
	localparam int PIN_W     = 4;

	localparam logic [LATCH_W-1:0] PIN_MASK =
		LATCH_W'((64'd1 << PIN_COUNT) - 64'd1);
	localparam logic [DATA_W-1:0] CONFIG_RESET = 32'h4444_4444;

	localparam logic [1:0] ACT_READ  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_PIN   = 2'd2;

	localparam logic [ADDR_W-1:0] OFF_CRL  = 10'h000;
	localparam logic [ADDR_W-1:0] OFF_CRH  = 10'h004;
	localparam logic [ADDR_W-1:0] OFF_IDR  = 10'h008;
	localparam logic [ADDR_W-1:0] OFF_ODR  = 10'h00C;
	localparam logic [ADDR_W-1:0] OFF_BSRR = 10'h010;
	localparam logic [ADDR_W-1:0] OFF_BRR  = 10'h014;
	localparam logic [ADDR_W-1:0] OFF_LCKR = 10'h018;

	localparam logic [1:0] MODE_INPUT     = 2'd0;
	localparam logic [1:0] CNF_PUSH_PULL  = 2'd0;
	localparam logic [1:0] CNF_OPEN_DRAIN = 2'd1;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_ERR,
		OP_RD_CRL,
		OP_RD_CRH,
		OP_RD_IDR,
		OP_RD_ODR,
		OP_RD_LCKR,
		OP_WR_CRL,
		OP_WR_CRH,
		OP_WR_ODR,
		OP_WR_BSRR,
		OP_WR_BRR,
		OP_WR_LCKR,
		OP_PIN
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [DATA_W-1:0] data;
		logic [PIN_W-1:0]  pin;
		logic              level;
	} entry_t;

endpackage

/* rtl/gpsr_in_if.sv */
// request channel: bus access or pin level event
interface gpsr_in_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  action;
	logic [gpsr_pkg::ADDR_W-1:0] address;
	logic [gpsr_pkg::DATA_W-1:0] write_data;
	logic [gpsr_pkg::PIN_W-1:0]  pin_num;
	logic                        pin_level;

	modport source(output valid, action, address, write_data, pin_num, pin_level,
		input ready);
	modport sink(input valid, action, address, write_data, pin_num, pin_level,
		output ready);
endinterface

/* rtl/gpsr_out_if.sv */
// response channel: read data, pin drive events and error flag
interface gpsr_out_if;
	logic                         valid;
	logic                         ready;
	logic [gpsr_pkg::DATA_W-1:0]  read_data;
	logic [gpsr_pkg::LATCH_W-1:0] drive_mask;
	logic [gpsr_pkg::LATCH_W-1:0] drive_levels;
	logic                         access_error;

	modport source(output valid, read_data, drive_mask, drive_levels, access_error,
		input ready);
	modport sink(input valid, read_data, drive_mask, drive_levels, access_error,
		output ready);
endinterface

/* rtl/gpsr_front.sv */
// front end: decodes action and offset of each item into an operation
module gpsr_front (
	gpsr_in_if.sink          req,
	input  logic             q_full,
	output logic             push,
	output gpsr_pkg::entry_t push_entry
);

	gpsr_pkg::op_t op;

	always_comb begin
		op = gpsr_pkg::OP_NOP;
		case (req.action)
			gpsr_pkg::ACT_READ: begin
				case (req.address)
					gpsr_pkg::OFF_CRL:  op = gpsr_pkg::OP_RD_CRL;
					gpsr_pkg::OFF_CRH:  op = gpsr_pkg::OP_RD_CRH;
					gpsr_pkg::OFF_IDR:  op = gpsr_pkg::OP_RD_IDR;
					gpsr_pkg::OFF_ODR:  op = gpsr_pkg::OP_RD_ODR;
					gpsr_pkg::OFF_LCKR: op = gpsr_pkg::OP_RD_LCKR;
					default:            op = gpsr_pkg::OP_ERR;
				endcase
			end
			gpsr_pkg::ACT_WRITE: begin
				case (req.address)
					gpsr_pkg::OFF_CRL:  op = gpsr_pkg::OP_WR_CRL;
					gpsr_pkg::OFF_CRH:  op = gpsr_pkg::OP_WR_CRH;
					gpsr_pkg::OFF_ODR:  op = gpsr_pkg::OP_WR_ODR;
					gpsr_pkg::OFF_BSRR: op = gpsr_pkg::OP_WR_BSRR;
					gpsr_pkg::OFF_BRR:  op = gpsr_pkg::OP_WR_BRR;
					gpsr_pkg::OFF_LCKR: op = gpsr_pkg::OP_WR_LCKR;
					default:            op = gpsr_pkg::OP_ERR;
				endcase
			end
			gpsr_pkg::ACT_PIN: begin
				if ({1'b0, req.pin_num} < (gpsr_pkg::PIN_W+1)'(gpsr_pkg::PIN_COUNT)) begin
					op = gpsr_pkg::OP_PIN;
				end else begin
					op = gpsr_pkg::OP_ERR;
				end
			end
			default: op = gpsr_pkg::OP_NOP;
		endcase
	end

	assign req.ready        = !q_full;
	assign push             = req.valid && !q_full;
	assign push_entry.op    = op;
	assign push_entry.data  = req.write_data;
	assign push_entry.pin   = req.pin_num;
	assign push_entry.level = req.pin_level;

endmodule

/* rtl/gpsr_queue.sv */
// two-entry queue between decode and execute
module gpsr_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  gpsr_pkg::entry_t push_entry,
	output logic             full,
	output logic             q_valid,
	output gpsr_pkg::entry_t q_entry,
	input  logic             pop
);

	gpsr_pkg::entry_t mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	assign full    = (count_q == 2'd2);
	assign q_valid = (count_q != 2'd0);
	assign q_entry = mem_q[rd_ptr_q];

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 2'd1)
		else $error("queue count did not grow on push");

endmodule

/* rtl/gpsr_back.sv */
// back end: register file, latch update, pin drive and response register
module gpsr_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  gpsr_pkg::entry_t q_entry,
	output logic             pop,
	gpsr_out_if.source       rsp
);

	logic [gpsr_pkg::DATA_W-1:0]  crl_q;
	logic [gpsr_pkg::DATA_W-1:0]  crh_q;
	logic [gpsr_pkg::LATCH_W-1:0] inputs_q;
	logic [gpsr_pkg::LATCH_W-1:0] latch_q;
	logic [gpsr_pkg::DATA_W-1:0]  lock_q;

	logic                         out_valid_q;
	logic [gpsr_pkg::DATA_W-1:0]  rd_q;
	logic [gpsr_pkg::LATCH_W-1:0] mask_q;
	logic [gpsr_pkg::LATCH_W-1:0] lvl_q;
	logic                         err_q;

	logic [2*gpsr_pkg::DATA_W-1:0] cfg;
	logic [gpsr_pkg::LATCH_W-1:0]  latch_nx;
	logic [gpsr_pkg::LATCH_W-1:0]  mask_all;
	logic [gpsr_pkg::LATCH_W-1:0]  lvl_all;
	logic                          drives;
	logic                          pin_out;
	logic [gpsr_pkg::DATA_W-1:0]   rd;
	logic                          err;
	logic [3:0]                    field;

	assign cfg     = {crh_q, crl_q};
	assign pin_out = cfg[{q_entry.pin, 2'b00} +: 2] != gpsr_pkg::MODE_INPUT;
	assign pop     = q_valid && (!out_valid_q || rsp.ready);

	always_comb begin
		latch_nx = latch_q;
		drives   = 1'b0;
		case (q_entry.op)
			gpsr_pkg::OP_WR_ODR: begin
				latch_nx = q_entry.data[gpsr_pkg::LATCH_W-1:0];
				drives   = 1'b1;
			end
			gpsr_pkg::OP_WR_BSRR: begin
				latch_nx = (latch_q & ~q_entry.data[2*gpsr_pkg::LATCH_W-1:gpsr_pkg::LATCH_W])
					| q_entry.data[gpsr_pkg::LATCH_W-1:0];
				drives   = 1'b1;
			end
			gpsr_pkg::OP_WR_BRR: begin
				latch_nx = latch_q & ~q_entry.data[gpsr_pkg::LATCH_W-1:0];
				drives   = 1'b1;
			end
			default: latch_nx = latch_q;
		endcase
	end

	// per-pin drive from the updated latch
	always_comb begin
		mask_all = '0;
		lvl_all  = '0;
		field    = '0;
		for (int p = 0; p < gpsr_pkg::PIN_COUNT; p++) begin
			field = cfg[p*4 +: 4];
			if (field[1:0] != gpsr_pkg::MODE_INPUT) begin
				if (field[3:2] == gpsr_pkg::CNF_PUSH_PULL) begin
					mask_all[p] = 1'b1;
					lvl_all[p]  = latch_nx[p];
				end else if (field[3:2] == gpsr_pkg::CNF_OPEN_DRAIN && !latch_nx[p]) begin
					mask_all[p] = 1'b1;
				end
			end
		end
	end

	always_comb begin
		rd  = '0;
		err = 1'b0;
		case (q_entry.op)
			gpsr_pkg::OP_RD_CRL:  rd = crl_q;
			gpsr_pkg::OP_RD_CRH:  rd = crh_q;
			gpsr_pkg::OP_RD_IDR:  rd = gpsr_pkg::DATA_W'(inputs_q);
			gpsr_pkg::OP_RD_ODR:  rd = gpsr_pkg::DATA_W'(latch_q);
			gpsr_pkg::OP_RD_LCKR: rd = lock_q;
			gpsr_pkg::OP_ERR:     err = 1'b1;
			gpsr_pkg::OP_PIN:     err = pin_out;
			default:              rd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crl_q    <= gpsr_pkg::CONFIG_RESET;
			crh_q    <= gpsr_pkg::CONFIG_RESET;
			inputs_q <= '0;
			latch_q  <= '0;
			lock_q   <= '0;
		end else if (pop) begin
			latch_q <= latch_nx;
			case (q_entry.op)
				gpsr_pkg::OP_WR_CRL:  crl_q  <= q_entry.data;
				gpsr_pkg::OP_WR_CRH:  crh_q  <= q_entry.data;
				gpsr_pkg::OP_WR_LCKR: lock_q <= q_entry.data;
				gpsr_pkg::OP_PIN: begin
					if (!pin_out) begin
						inputs_q[q_entry.pin] <= q_entry.level;
					end
				end
				default: lock_q <= lock_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rd_q   <= rd;
			mask_q <= drives ? (mask_all & gpsr_pkg::PIN_MASK) : '0;
			lvl_q  <= drives ? (lvl_all & gpsr_pkg::PIN_MASK) : '0;
			err_q  <= err;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.read_data    = rd_q;
	assign rsp.drive_mask   = mask_q;
	assign rsp.drive_levels = lvl_q;
	assign rsp.access_error = err_q;

	a_levels_in_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (lvl_q & ~mask_q) == '0)
		else $error("drive level outside drive mask");

	a_error_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && err_q |-> mask_q == '0 && rd_q == '0)
		else $error("error item carries data");

	a_refused_pin: assert property (@(posedge clk) disable iff (!arst_n)
		pop && q_entry.op == gpsr_pkg::OP_PIN && pin_out |=> inputs_q == $past(inputs_q))
		else $error("input levels changed on refused pin event");

endmodule

/* rtl/gpio_port_set_reset_open_drain.sv */
// top level of the 16-pin gpio port with bit set/reset and open-drain drive
// path: an accepted item is stored in the queue, then executed into the response register
// throughput: one item per cycle; back end executes one per cycle unless rsp stalls
// stalls: a two-entry queue and the response register absorb output back-pressure
// reset: config words 0x44444444, input levels, latch and lock word cleared, queue empty
module gpio_port_set_reset_open_drain (
	input logic        clk,
	input logic        arst_n,
	gpsr_in_if.sink    req,
	gpsr_out_if.source rsp
);

	logic             q_full;
	logic             push;
	gpsr_pkg::entry_t push_entry;
	logic             q_valid;
	gpsr_pkg::entry_t q_entry;
	logic             pop;

	gpsr_front u_front (
		.req       (req),
		.q_full    (q_full),
		.push      (push),
		.push_entry(push_entry)
	);

	gpsr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (q_full),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.pop       (pop)
	);

	gpsr_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(q_valid),
		.q_entry(q_entry),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

/* verif/tb_gpio_port_set_reset_open_drain.sv */
// testbench for the gpio port: register accesses and pin events checked against a mirror
module tb_gpio_port_set_reset_open_drain;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] ACT_NONE = 2'd3;

	typedef struct {
		logic [gpsr_pkg::DATA_W-1:0]  read_data;
		logic [gpsr_pkg::LATCH_W-1:0] drive_mask;
		logic [gpsr_pkg::LATCH_W-1:0] drive_levels;
		logic                         access_error;
	} port_response_t;

	class port_mirror;
		logic [gpsr_pkg::DATA_W-1:0]  crl;
		logic [gpsr_pkg::DATA_W-1:0]  crh;
		logic [gpsr_pkg::LATCH_W-1:0] idr;
		logic [gpsr_pkg::LATCH_W-1:0] odr;
		logic [gpsr_pkg::DATA_W-1:0]  lckr;
		port_response_t               awaited_responses[$];
		int                           mismatches;

		function new();
			crl = gpsr_pkg::CONFIG_RESET;
			crh = gpsr_pkg::CONFIG_RESET;
			idr = '0;
			odr = '0;
			lckr = '0;
			mismatches = 0;
		endfunction

		function logic [3:0] pin_field(int unsigned pin);
			logic [gpsr_pkg::DATA_W-1:0] word;
			word = (pin < 8) ? crl : crh;
			return word[(pin % 8) * 4 +: 4];
		endfunction

		function void drive_pins(output logic [gpsr_pkg::LATCH_W-1:0] mask,
			output logic [gpsr_pkg::LATCH_W-1:0] levels);
			logic [3:0] f;
			mask = '0;
			levels = '0;
			for (int unsigned p = 0; p < gpsr_pkg::PIN_COUNT; p++) begin
				f = pin_field(p);
				if (f[1:0] != gpsr_pkg::MODE_INPUT) begin
					if (f[3:2] == gpsr_pkg::CNF_PUSH_PULL) begin
						mask[p] = 1'b1;
						levels[p] = odr[p];
					end else if (f[3:2] == gpsr_pkg::CNF_OPEN_DRAIN && !odr[p]) begin
						mask[p] = 1'b1;
					end
				end
			end
			mask &= gpsr_pkg::PIN_MASK;
			levels &= gpsr_pkg::PIN_MASK;
		endfunction

		function void note_access(logic [1:0] action, logic [gpsr_pkg::ADDR_W-1:0] address,
			logic [gpsr_pkg::DATA_W-1:0] data, logic [gpsr_pkg::PIN_W-1:0] pin,
			logic level);
			port_response_t r;
			logic [3:0]     pf;
			r.read_data = '0;
			r.drive_mask = '0;
			r.drive_levels = '0;
			r.access_error = 1'b0;
			case (action)
				gpsr_pkg::ACT_READ: begin
					case (address)
						gpsr_pkg::OFF_CRL: r.read_data = crl;
						gpsr_pkg::OFF_CRH: r.read_data = crh;
						gpsr_pkg::OFF_IDR: r.read_data = gpsr_pkg::DATA_W'(idr);
						gpsr_pkg::OFF_ODR: r.read_data = gpsr_pkg::DATA_W'(odr);
						gpsr_pkg::OFF_LCKR: r.read_data = lckr;
						default: r.access_error = 1'b1;
					endcase
				end
				gpsr_pkg::ACT_WRITE: begin
					case (address)
						gpsr_pkg::OFF_CRL: crl = data;
						gpsr_pkg::OFF_CRH: crh = data;
						gpsr_pkg::OFF_ODR: begin
							odr = data[gpsr_pkg::LATCH_W-1:0];
							drive_pins(r.drive_mask, r.drive_levels);
						end
						gpsr_pkg::OFF_BSRR: begin
							odr = (odr & ~data[31:16]) | data[15:0];
							drive_pins(r.drive_mask, r.drive_levels);
						end
						gpsr_pkg::OFF_BRR: begin
							odr = odr & ~data[15:0];
							drive_pins(r.drive_mask, r.drive_levels);
						end
						gpsr_pkg::OFF_LCKR: lckr = data;
						default: r.access_error = 1'b1;
					endcase
				end
				gpsr_pkg::ACT_PIN: begin
					pf = pin_field(pin);
					if (int'(pin) >= gpsr_pkg::PIN_COUNT || pf[1:0] != gpsr_pkg::MODE_INPUT)
						r.access_error = 1'b1;
					else
						idr[pin] = level;
				end
				default: ;
			endcase
			awaited_responses.push_back(r);
		endfunction

		function void check_response(port_response_t got);
			port_response_t exp;
			if (awaited_responses.size() == 0) begin
				$error("unexpected result: read_data %h drive_mask %h drive_levels %h err %b",
					got.read_data, got.drive_mask, got.drive_levels, got.access_error);
				mismatches++;
				return;
			end
			exp = awaited_responses.pop_front();
			if (got.read_data !== exp.read_data) begin
				$error("read_data: expected %h, actual %h", exp.read_data, got.read_data);
				mismatches++;
			end
			if (got.drive_mask !== exp.drive_mask) begin
				$error("drive_mask: expected %h, actual %h", exp.drive_mask, got.drive_mask);
				mismatches++;
			end
			if (got.drive_levels !== exp.drive_levels) begin
				$error("drive_levels: expected %h, actual %h", exp.drive_levels,
					got.drive_levels);
				mismatches++;
			end
			if (got.access_error !== exp.access_error) begin
				$error("access_error: expected %b, actual %b", exp.access_error,
					got.access_error);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   no_idle;

	gpsr_in_if  req ();
	gpsr_out_if rsp ();

	port_mirror mirror;

	gpio_port_set_reset_open_drain u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	task automatic issue_access(logic [1:0] action, logic [gpsr_pkg::ADDR_W-1:0] address,
		logic [gpsr_pkg::DATA_W-1:0] data, logic [gpsr_pkg::PIN_W-1:0] pin, logic level);
		int  gap;
		bit  fire;
		gap = no_idle ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.action <= action;
		req.address <= address;
		req.write_data <= data;
		req.pin_num <= pin;
		req.pin_level <= level;
		do begin
			@(negedge clk);
			fire = (req.ready === 1'b1);
			@(posedge clk);
		end while (!fire);
		mirror.note_access(action, address, data, pin, level);
	endtask

	function automatic logic [gpsr_pkg::DATA_W-1:0] random_config();
		logic [gpsr_pkg::DATA_W-1:0] w;
		for (int i = 0; i < 8; i++) begin
			w[i*4 +: 2] = $urandom_range(0, 1) ? gpsr_pkg::MODE_INPUT :
				2'($urandom_range(1, 3));
			w[i*4+2 +: 2] = 2'($urandom_range(0, 3));
		end
		return w;
	endfunction

	// result side: random stall per result, each result checked while it is being accepted
	initial begin
		int             stall;
		bit             fire;
		port_response_t got;
		rsp.ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 17);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do begin
				@(negedge clk);
				fire = (rsp.valid === 1'b1);
				if (fire) begin
					got.read_data = rsp.read_data;
					got.drive_mask = rsp.drive_mask;
					got.drive_levels = rsp.drive_levels;
					got.access_error = rsp.access_error;
					mirror.check_response(got);
				end
				@(posedge clk);
			end while (!fire);
		end
	end

	initial begin
		int                           r;
		logic [1:0]                   action;
		logic [gpsr_pkg::ADDR_W-1:0]  address;
		logic [gpsr_pkg::DATA_W-1:0]  data;
		mirror = new();
		no_idle = 1'b0;
		arst_n = 1'b0;
		req.valid <= 1'b0;
		req.action <= gpsr_pkg::ACT_READ;
		req.address <= '0;
		req.write_data <= '0;
		req.pin_num <= '0;
		req.pin_level <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values
		issue_access(gpsr_pkg::ACT_READ, gpsr_pkg::OFF_CRL, '0, '0, 1'b0);
		issue_access(gpsr_pkg::ACT_READ, gpsr_pkg::OFF_CRH, '0, '0, 1'b0);
		issue_access(gpsr_pkg::ACT_READ, gpsr_pkg::OFF_IDR, '0, '0, 1'b0);
		issue_access(gpsr_pkg::ACT_READ, gpsr_pkg::OFF_LCKR, '0, '0, 1'b0);
		issue_access(gpsr_pkg::ACT_WRITE, gpsr_pkg::OFF_LCKR, 32'hFFFF_FFFF, '0, 1'b0);
		issue_access(gpsr_pkg::ACT_READ, gpsr_pkg::OFF_LCKR, '0, '0, 1'b0);
		// push-pull, open-drain, cnf 2 and 3, inputs on the high pins
		issue_access(gpsr_pkg::ACT_WRITE, gpsr_pkg::OFF_CRL, 32'h7340_D951, '0, 1'b0);
		issue_access(gpsr_pkg::ACT_WRITE, gpsr_pkg::OFF_CRH, 32'h0000_0000, '0, 1'b0);
		issue_access(gpsr_pkg::ACT_WRITE, gpsr_pkg::OFF_ODR, 32'hFFFF_FFFF, '0, 1'b0);
		// set wins over reset on bit 0
		issue_access(gpsr_pkg::ACT_WRITE, gpsr_pkg::OFF_BSRR, 32'h0003_0001, '0, 1'b0);
		issue_access(gpsr_pkg::ACT_WRITE, gpsr_pkg::OFF_BRR, 32'hFFFF_FFFF, '0, 1'b0);
		issue_access(gpsr_pkg::ACT_WRITE, gpsr_pkg::OFF_ODR, 32'h0000_0000, '0, 1'b0);
		issue_access(gpsr_pkg::ACT_READ, gpsr_pkg::OFF_ODR, '0, '0, 1'b0);
		issue_access(gpsr_pkg::ACT_READ, gpsr_pkg::OFF_BSRR, '0, '0, 1'b0);
		issue_access(gpsr_pkg::ACT_READ, gpsr_pkg::OFF_BRR, '0, '0, 1'b0);
		issue_access(gpsr_pkg::ACT_WRITE, gpsr_pkg::OFF_IDR, 32'hFFFF_FFFF, '0, 1'b0);
		issue_access(gpsr_pkg::ACT_READ, 10'h3FF, '0, '0, 1'b0);
		issue_access(gpsr_pkg::ACT_WRITE, 10'h001, 32'hA5A5_A5A5, '0, 1'b0);
		issue_access(gpsr_pkg::ACT_PIN, '0, '0, 4'd15, 1'b1);
		issue_access(gpsr_pkg::ACT_PIN, '0, '0, 4'd0, 1'b1);
		issue_access(gpsr_pkg::ACT_PIN, '0, '0, 4'd4, 1'b1);
		issue_access(gpsr_pkg::ACT_READ, gpsr_pkg::OFF_IDR, '0, '0, 1'b0);
		issue_access(ACT_NONE, 10'h3FF, 32'hFFFF_FFFF, 4'd15, 1'b1);
		issue_access(gpsr_pkg::ACT_PIN, '0, '0, 4'd15, 1'b0);
		issue_access(gpsr_pkg::ACT_WRITE, gpsr_pkg::OFF_CRH, 32'hFFFF_FFFF, '0, 1'b0);

		for (int i = 0; i < 1600; i++) begin
			no_idle = ((i / 200) % 3) == 1;
			r = $urandom_range(0, 99);
			action = (r < 35) ? gpsr_pkg::ACT_READ : (r < 75) ? gpsr_pkg::ACT_WRITE :
				(r < 95) ? gpsr_pkg::ACT_PIN : ACT_NONE;
			if ($urandom_range(0, 99) < 88) begin
				case ($urandom_range(0, 6))
					0: address = gpsr_pkg::OFF_CRL;
					1: address = gpsr_pkg::OFF_CRH;
					2: address = gpsr_pkg::OFF_IDR;
					3: address = gpsr_pkg::OFF_ODR;
					4: address = gpsr_pkg::OFF_BSRR;
					5: address = gpsr_pkg::OFF_BRR;
					default: address = gpsr_pkg::OFF_LCKR;
				endcase
			end else begin
				address = gpsr_pkg::ADDR_W'($urandom);
			end
			data = (address == gpsr_pkg::OFF_CRL || address == gpsr_pkg::OFF_CRH) &&
				$urandom_range(0, 3) != 0 ? random_config() : $urandom;
			issue_access(action, address, data, gpsr_pkg::PIN_W'($urandom), 1'($urandom));
		end
		req.valid <= 1'b0;

		while (mirror.awaited_responses.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mirror.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
